// ----- src/lis_pkg.sv -----
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants and controller/datapath interface types for the
// longest increasing subsequence block.
// ----------------------------------------------------------------------------
`default_nettype none

package lis_pkg;

  localparam int LIS_MAX_LEN     = 1024;
  localparam int LIS_VALUE_WIDTH = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture transaction, set up search bounds
    logic probe;   // issue first table read if the range is not empty
    logic step;    // compare read data, narrow range, issue next read
    logic commit;  // write the table, update length, load result
  } lis_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic probe_go;  // search range is not empty
    logic step_go;   // range stays non-empty after this step
  } lis_sts_t;

endpackage

`default_nettype wire

// ----- src/lis_ctrl.sv -----
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer for one transaction: load, binary search, commit and result
// handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire lis_pkg::lis_sts_t sts,
  output lis_pkg::lis_cmd_t      cmd
);
  import lis_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PROBE  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe  = 1'b1;
        state_next = sts.probe_go ? S_SEARCH : S_COMMIT;
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (!sts.step_go) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.commit || (out_valid && out_stall);
    end
  end

endmodule

`default_nettype wire

// ----- src/lis_dp.sv -----
// ----------------------------------------------------------------------------
// lis_dp
// Tails table, search bounds, running length and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_dp #(
  parameter int MAX_LEN     = lis_pkg::LIS_MAX_LEN,
  parameter int VALUE_WIDTH = lis_pkg::LIS_VALUE_WIDTH,
  parameter int LEN_W       = $clog2(MAX_LEN + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic                          start_req,
  input  wire lis_pkg::lis_cmd_t             cmd,
  output lis_pkg::lis_sts_t                  sts,
  output logic             [LEN_W-1:0]       run_length,
  output logic                               overflow
);
  import lis_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  logic [VALUE_WIDTH-1:0] tails [MAX_LEN];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [VALUE_WIDTH-1:0] key;
  logic [LEN_W-1:0]       length;
  logic [LEN_W-1:0]       lo;
  logic [LEN_W-1:0]       hi;
  logic [LEN_W-1:0]       mid;
  logic [LEN_W-1:0]       lo_next;
  logic [LEN_W-1:0]       hi_next;
  logic [LEN_W-1:0]       mid_probe;
  logic [LEN_W-1:0]       mid_step;
  logic [LEN_W:0]         sum_probe;
  logic [LEN_W:0]         sum_step;
  logic                   less;
  logic                   rd_en;
  logic [LEN_W-1:0]       rd_addr;
  logic                   hit;
  logic                   room;

  // offset-binary key: unsigned compare gives signed order
  logic [VALUE_WIDTH-1:0] key_in;
  assign key_in = {~value[VALUE_WIDTH-1], value[VALUE_WIDTH-2:0]};

  assign less      = (rd_data < key);
  assign lo_next   = less ? (mid + LEN_W'(1)) : lo;
  assign hi_next   = less ? hi : mid;
  assign sum_probe = {1'b0, lo} + {1'b0, hi};
  assign sum_step  = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_probe = sum_probe[LEN_W:1];
  assign mid_step  = sum_step[LEN_W:1];

  assign sts.probe_go = (lo < hi);
  assign sts.step_go  = (lo_next < hi_next);

  assign rd_en   = (cmd.probe && sts.probe_go) || (cmd.step && sts.step_go);
  assign rd_addr = cmd.probe ? mid_probe : mid_step;

  assign hit  = (lo < length);
  assign room = (length < LEN_MAX);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= tails[rd_addr[AW-1:0]];
    end
    if (cmd.commit && (hit || room)) begin
      tails[lo[AW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= key_in;
      lo  <= '0;
      hi  <= start_req ? '0 : length;
    end else if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (rd_en) begin
      mid <= rd_addr;
    end
    if (cmd.commit) begin
      run_length <= (!hit && room) ? (length + LEN_W'(1)) : length;
      overflow   <= !hit && !room;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.load && start_req) begin
      length <= '0;
    end else if (cmd.commit && !hit && room) begin
      length <= length + LEN_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- src/longest_increasing_subsequence_top.sv -----
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_top
// Running longest strictly increasing subsequence length, patience method
// with a binary search over a tails table held in block memory.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid / in_stall  value, start_req
//  output    out_valid/ out_stall run_length, overflow
//
//  one transaction at a time: accept, a setup step that issues the first
//  table read, one search step per halving of the search range (at most
//  ceil(log2(length+1)) halvings), then the commit; the single table read
//  port and its registered data set this sequence.
//  the result register frees the input side: a new transaction is taken
//  while the last result is still stalled, it waits only at commit.
//  reset clears the length and the handshake state; the table needs none.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_increasing_subsequence_top #(
  parameter int MAX_LEN     = lis_pkg::LIS_MAX_LEN,
  parameter int VALUE_WIDTH = lis_pkg::LIS_VALUE_WIDTH,
  parameter int LEN_W       = $clog2(MAX_LEN + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic                          start_req,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic             [LEN_W-1:0]       run_length,
  output logic                               overflow
);
  import lis_pkg::*;

  lis_cmd_t cmd;
  lis_sts_t sts;

  lis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lis_dp #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH),
    .LEN_W       (LEN_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .start_req  (start_req),
    .cmd        (cmd),
    .sts        (sts),
    .run_length (run_length),
    .overflow   (overflow)
  );

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_length <= LEN_W'(MAX_LEN)))
    else $error("run length above table capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (run_length == LEN_W'(MAX_LEN)))
    else $error("overflow flagged with table not full");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("commit over a stalled result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !out_valid || in_stall))
    else $error("input taken again before the search ran");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (!in_stall && out_valid))
    else $error("commit did not return to idle with a result");

endmodule

`default_nettype wire
